@@ sv/aerd_pkg.sv @@
// aerd_pkg: shared types and constants of the address-event record decoder
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package aerd_pkg;

    // record format register codes (code 3 behaves as the 8-byte format)
    localparam logic [1:0] FMT_4BYTE = 2'd0;
    localparam logic [1:0] FMT_6BYTE = 2'd1;
    localparam logic [1:0] FMT_8BYTE = 2'd2;
    localparam logic [1:0] FMT_RESET = FMT_6BYTE;

    // last byte position of each record size
    localparam logic [2:0] LAST_POS_4BYTE = 3'd3;
    localparam logic [2:0] LAST_POS_6BYTE = 3'd5;
    localparam logic [2:0] LAST_POS_8BYTE = 3'd7;

    // record kinds
    localparam logic [1:0] KIND_EVENT    = 2'd0;
    localparam logic [1:0] KIND_WRAP     = 2'd1;
    localparam logic [1:0] KIND_TS_RESET = 2'd2;

    localparam logic [31:0] WRAP_STEP = 32'h0000_4000;

    // register word indexes on the config port
    localparam logic REG_RECORD_FORMAT = 1'b0;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 7;
    localparam int TS_W    = 32;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 3;
    localparam int STORE_DEPTH = 7;

    // registered input byte, passed from the input stage to the record core
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_stage;

endpackage

`default_nettype wire

@@ sv/aerd_if.sv @@
// aerd_byte_if and aerd_rec_if: valid/ready channels of the record decoder
// depends on aerd_pkg for field widths
`default_nettype none

interface aerd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [aerd_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aerd_rec_if;
    logic                        valid;
    logic                        ready;
    logic [aerd_pkg::COORD_W-1:0] x_address;
    logic [aerd_pkg::COORD_W-1:0] y_address;
    logic                        polarity_on;
    logic [aerd_pkg::TS_W-1:0]    timestamp;
    logic                        address_flag;
    logic [aerd_pkg::KIND_W-1:0]  record_kind;
    logic                        end_of_body;

    modport source (
        output valid, output x_address, output y_address, output polarity_on,
        output timestamp, output address_flag, output record_kind, output end_of_body,
        input ready
    );
    modport sink (
        input valid, input x_address, input y_address, input polarity_on,
        input timestamp, input address_flag, input record_kind, input end_of_body,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/aerd_apb_regs.sv @@
// aerd_apb_regs: apb-style register file holding the record format
// depends on aerd_pkg
`default_nettype none

module aerd_apb_regs #(
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output logic      [1:0]        o_record_format
);

    logic [1:0] r_record_format;
    logic       sel_fmt;

    assign sel_fmt = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(aerd_pkg::REG_RECORD_FORMAT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_format <= aerd_pkg::FMT_RESET;
        end else if (psel && penable && pwrite && pready && sel_fmt) begin
            r_record_format <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_fmt) begin
            prdata = {30'd0, r_record_format};
        end
    end

    assign pready          = 1'b1;
    assign o_record_format = r_record_format;

endmodule

`default_nettype wire

@@ sv/aerd_input_stage.sv @@
// aerd_input_stage: input register for the byte stream
// depends on aerd_pkg and aerd_byte_if
`default_nettype none

module aerd_input_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    aerd_byte_if.sink          s_byte,
    input  wire logic          i_advance,
    output aerd_pkg::t_in_stage o_in
);

    logic                        r_vld;
    logic [aerd_pkg::BYTE_W-1:0] r_data;
    logic                        r_last;
    logic                        accept;

    // the held byte leaves in the same cycle a new one may come in
    assign s_byte.ready = !r_vld || i_advance;
    assign accept       = s_byte.valid && s_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= s_byte.data_byte;
            r_last <= s_byte.last_byte;
        end
    end

    assign o_in.valid     = r_vld;
    assign o_in.data_byte = r_data;
    assign o_in.last_byte = r_last;

endmodule

`default_nettype wire

@@ sv/aerd_record_core.sv @@
// aerd_record_core: record assembly, field decode, wrap offset and result register
// depends on aerd_pkg and aerd_rec_if
`default_nettype none

module aerd_record_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire aerd_pkg::t_in_stage i_in,
    input  wire logic [1:0]          i_record_format,
    output logic                     o_advance,
    aerd_rec_if.source               m_rec
);

    logic [aerd_pkg::POS_W-1:0]  r_pos;
    logic [aerd_pkg::POS_W-1:0]  n_pos;
    logic [aerd_pkg::BYTE_W-1:0] r_bytes [aerd_pkg::STORE_DEPTH];
    logic [31:0]                 r_wrap;
    logic [31:0]                 n_wrap;

    logic                         r_out_vld;
    logic [aerd_pkg::COORD_W-1:0] r_x;
    logic [aerd_pkg::COORD_W-1:0] r_y;
    logic                         r_pol;
    logic [aerd_pkg::TS_W-1:0]    r_ts;
    logic                         r_flag;
    logic [aerd_pkg::KIND_W-1:0]  r_kind;
    logic                         r_eob;

    logic [aerd_pkg::POS_W-1:0]  last_pos;
    logic                        complete;
    logic [15:0]                 addr;
    logic [aerd_pkg::TS_W-1:0]   ts;
    logic [aerd_pkg::KIND_W-1:0] kind;
    logic [aerd_pkg::BYTE_W-1:0] cur;

    assign cur       = i_in.data_byte;
    assign o_advance = i_in.valid && (!r_out_vld || m_rec.ready);

    always_comb begin
        case (i_record_format)
            aerd_pkg::FMT_4BYTE: last_pos = aerd_pkg::LAST_POS_4BYTE;
            aerd_pkg::FMT_6BYTE: last_pos = aerd_pkg::LAST_POS_6BYTE;
            default:             last_pos = aerd_pkg::LAST_POS_8BYTE;
        endcase
    end

    // a record closes once the position reaches its last byte, also after a format change
    assign complete = (r_pos >= last_pos);

    always_comb begin
        n_wrap = r_wrap;
        kind   = aerd_pkg::KIND_EVENT;
        addr   = {r_bytes[1], r_bytes[0]};
        ts     = '0;
        case (i_record_format)
            aerd_pkg::FMT_4BYTE: begin
                if (cur[7]) begin
                    n_wrap = r_wrap + aerd_pkg::WRAP_STEP;
                    kind   = aerd_pkg::KIND_WRAP;
                end else if (cur[6]) begin
                    n_wrap = '0;
                    kind   = aerd_pkg::KIND_TS_RESET;
                end
                ts = {16'd0, cur, r_bytes[2]} + r_wrap;
            end
            aerd_pkg::FMT_6BYTE: begin
                ts = {r_bytes[2], r_bytes[3], r_bytes[4], cur};
            end
            default: begin
                // big-endian address: only the low half is used
                addr = {r_bytes[2], r_bytes[3]};
                ts   = {r_bytes[4], r_bytes[5], r_bytes[6], cur};
            end
        endcase
    end

    always_comb begin
        if (complete) begin
            n_pos = '0;
        end else if (i_in.last_byte) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wrap <= '0;
        end else if (o_advance) begin
            r_pos <= n_pos;
            if (complete) begin
                r_wrap <= n_wrap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && !complete) begin
            r_bytes[r_pos] <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_advance && complete) begin
            r_out_vld <= 1'b1;
        end else if (m_rec.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && complete) begin
            r_kind <= kind;
            r_eob  <= i_in.last_byte;
            if (kind != aerd_pkg::KIND_EVENT) begin
                r_x    <= '0;
                r_y    <= '0;
                r_pol  <= 1'b0;
                r_flag <= 1'b0;
                r_ts   <= n_wrap;
            end else begin
                r_x    <= addr[7:1];
                r_y    <= addr[14:8];
                r_pol  <= addr[0];
                r_flag <= addr[15];
                r_ts   <= ts;
            end
        end
    end

    assign m_rec.valid        = r_out_vld;
    assign m_rec.x_address    = r_x;
    assign m_rec.y_address    = r_y;
    assign m_rec.polarity_on  = r_pol;
    assign m_rec.timestamp    = r_ts;
    assign m_rec.address_flag = r_flag;
    assign m_rec.record_kind  = r_kind;
    assign m_rec.end_of_body  = r_eob;

endmodule

`default_nettype wire

@@ sv/aer_event_record_decoder_top.sv @@
// aer_event_record_decoder_top: address-event record decoder, top level
// depends on aerd_pkg, aerd_if, aerd_apb_regs, aerd_input_stage, aerd_record_core
//
//   channel   dir   port     payload
//   bytes     in    i_byte   data_byte, last_byte
//   records   out   o_rec    x/y address, polarity, timestamp, flag, kind, end of body
//   config    in    apb      record_format at byte address 0
//
// one byte per cycle unless the result register is held; a byte is held in the input
// register, and the record it closes is written from there into the result register.
// a transfer on i_byte is taken while a finished record waits, as long as the
// input register is empty or can move on; it stalls only when the result register is held.
// synchronous active-low reset clears byte position, wrap offset and valids;
// record_format resets to the 6-byte format.
`default_nettype none

module aer_event_record_decoder_top #(
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    aerd_byte_if.sink              i_byte,
    aerd_rec_if.source             o_rec,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic [1:0]          record_format;
    logic                advance;
    aerd_pkg::t_in_stage in_stage;

    aerd_apb_regs #(
        .ADDR_W (ADDR_W)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_record_format (record_format)
    );

    aerd_input_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_byte    (i_byte),
        .i_advance (advance),
        .o_in      (in_stage)
    );

    aerd_record_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_stage),
        .i_record_format (record_format),
        .o_advance       (advance),
        .m_rec           (o_rec)
    );

endmodule

`default_nettype wire
